FILE: rtl/clt_pkg.sv
// shared types, character codes and result kinds for the command-line tokenizer
// no dependencies

package clt_pkg;

    localparam int unsigned ARG_COUNT_MAX = 255;
    localparam logic [7:0] ARG_COUNT_CAP =
        (ARG_COUNT_MAX > 255) ? 8'd255 : 8'(ARG_COUNT_MAX);

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic REG_ARG_LIMIT = 1'b0;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_ARG_END  = 2'd1;
    localparam logic [1:0] KIND_LINE_END = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] arg_index;
    } result_t;

    // up to three results caused by one item
    typedef struct packed {
        logic          load;
        logic [1:0]    count;
        result_t [2:0] res;
    } group_t;

    function automatic result_t make_result(logic [1:0] kind, logic [7:0] data,
                                            logic [7:0] idx);
        result_t r;
        r.kind      = kind;
        r.data_byte = data;
        r.arg_index = idx;
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL);
    endfunction

endpackage

FILE: rtl/clt_cfg.sv
// apb register file holding the argument limit
// depends on clt_pkg

module clt_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [clt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [clt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [clt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [7:0]                       arg_limit
);
    import clt_pkg::*;

    logic       wr_en;
    logic [7:0] arg_limit_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ARG_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg_limit_reg <= 8'd0;
        end
        else if (wr_en)
        begin
            arg_limit_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ARG_LIMIT)
        begin
            prdata[7:0] = arg_limit_reg;
        end
    end

    assign arg_limit = arg_limit_reg;

endmodule

FILE: rtl/clt_scan.sv
// input register, scanner state and per-item decode into a result group
// depends on clt_pkg

module clt_scan (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  logic [7:0]      arg_limit,
    input  logic            grp_free,
    output clt_pkg::group_t grp
);
    import clt_pkg::*;

    typedef enum logic [2:0] {
        MODE_BETWEEN  = 3'b001,
        MODE_UNQUOTED = 3'b010,
        MODE_QUOTED   = 3'b100
    } scan_mode_t;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    scan_mode_t mode_reg, mode_next;
    logic       qd_reg, qd_next;
    logic       esc_reg, esc_next;
    logic [7:0] cnt_reg, cnt_next;

    logic          consume;
    logic [7:0]    eff_limit;
    logic [7:0]    b;
    result_t [2:0] res_next;
    logic [1:0]    n_next;
    logic          run;
    logic          closes;

    assign b         = in_byte_reg;
    assign consume   = in_valid_reg && grp_free;
    assign in_ready  = !in_valid_reg || consume;
    assign eff_limit = (arg_limit != 8'd0 && arg_limit < ARG_COUNT_CAP) ?
                       arg_limit : ARG_COUNT_CAP;

    always_comb
    begin
        res_next  = '0;
        n_next    = 2'd0;
        mode_next = mode_reg;
        qd_next   = qd_reg;
        esc_next  = esc_reg;
        cnt_next  = cnt_reg;
        run       = 1'b1;
        closes    = 1'b0;

        // a held backslash resolves against this byte
        if (esc_reg)
        begin
            esc_next = 1'b0;
            if (b == CH_DQUOTE || b == CH_SQUOTE || b == CH_BSLASH)
            begin
                run = 1'b0;
                if (cnt_next < eff_limit)
                begin
                    res_next[n_next] = make_result(KIND_BYTE, b, cnt_next);
                    n_next = n_next + 2'd1;
                end
            end
            else if (cnt_next < eff_limit)
            begin
                res_next[n_next] = make_result(KIND_BYTE, CH_BSLASH, cnt_next);
                n_next = n_next + 2'd1;
            end
        end

        if (run)
        begin
            unique case (mode_next) inside
                MODE_UNQUOTED, MODE_QUOTED:
                begin
                    if (b == CH_NUL)
                    begin
                        if (cnt_next < eff_limit)
                        begin
                            res_next[n_next] = make_result(KIND_ARG_END, CH_NUL, cnt_next);
                            n_next   = n_next + 2'd1;
                            cnt_next = cnt_next + 8'd1;
                        end
                        res_next[n_next] = make_result(KIND_LINE_END, CH_NUL, cnt_next);
                        n_next    = n_next + 2'd1;
                        mode_next = MODE_BETWEEN;
                        qd_next   = 1'b0;
                        esc_next  = 1'b0;
                        cnt_next  = 8'd0;
                    end
                    else
                    begin
                        if (mode_next == MODE_UNQUOTED)
                        begin
                            closes = is_space(b);
                        end
                        else
                        begin
                            closes = (b == CH_NL) || (b == (qd_next ? CH_DQUOTE : CH_SQUOTE));
                        end
                        if (closes)
                        begin
                            if (cnt_next < eff_limit)
                            begin
                                res_next[n_next] = make_result(KIND_ARG_END, CH_NUL, cnt_next);
                                n_next   = n_next + 2'd1;
                                cnt_next = cnt_next + 8'd1;
                            end
                            mode_next = MODE_BETWEEN;
                        end
                        else if (b == CH_BSLASH)
                        begin
                            esc_next = 1'b1;
                        end
                        else if (cnt_next < eff_limit)
                        begin
                            res_next[n_next] = make_result(KIND_BYTE, b, cnt_next);
                            n_next = n_next + 2'd1;
                        end
                    end
                end
                default:
                begin
                    if (b == CH_NUL)
                    begin
                        res_next[n_next] = make_result(KIND_LINE_END, CH_NUL, cnt_next);
                        n_next    = n_next + 2'd1;
                        mode_next = MODE_BETWEEN;
                        qd_next   = 1'b0;
                        esc_next  = 1'b0;
                        cnt_next  = 8'd0;
                    end
                    else if (is_space(b))
                    begin
                        mode_next = MODE_BETWEEN;
                    end
                    else if (b == CH_DQUOTE || b == CH_SQUOTE)
                    begin
                        mode_next = MODE_QUOTED;
                        qd_next   = (b == CH_DQUOTE);
                    end
                    else if (b == CH_BSLASH)
                    begin
                        mode_next = MODE_UNQUOTED;
                        esc_next  = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_UNQUOTED;
                        if (cnt_next < eff_limit)
                        begin
                            res_next[n_next] = make_result(KIND_BYTE, b, cnt_next);
                            n_next = n_next + 2'd1;
                        end
                    end
                end
            endcase
        end
    end

    assign grp.load  = consume && (n_next != 2'd0);
    assign grp.count = n_next;
    assign grp.res   = res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_BETWEEN;
            qd_reg       <= 1'b0;
            esc_reg      <= 1'b0;
            cnt_reg      <= 8'd0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (consume)
            begin
                mode_reg <= mode_next;
                qd_reg   <= qd_next;
                esc_reg  <= esc_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
    end

    // end of line always returns the scanner to its reset state
    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        consume && in_byte_reg == CH_NUL |=>
        mode_reg == MODE_BETWEEN && cnt_reg == 8'd0 && !esc_reg)
        else $error("scanner state not cleared after end of line");

    a_line_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        consume && in_byte_reg == CH_NUL |-> grp.load && grp.count != 2'd0)
        else $error("end of line produced no result");

    a_esc_in_arg: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> mode_reg != MODE_BETWEEN)
        else $error("backslash held outside an argument");

endmodule

FILE: rtl/clt_emit.sv
// result group buffer that hands out one result per cycle while out_ready is high
// depends on clt_pkg

module clt_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  clt_pkg::group_t grp,
    output logic            grp_free,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      data_byte,
    output logic [7:0]      arg_index,
    output logic            last
);
    import clt_pkg::*;

    result_t [2:0] slots_reg;
    logic [1:0]    cnt_reg;
    logic [1:0]    pos_reg;
    logic          take;
    logic          last_slot;
    result_t       cur;

    assign out_valid = (cnt_reg != 2'd0);
    assign take      = out_valid && out_ready;
    assign last_slot = (pos_reg == cnt_reg - 2'd1);
    assign grp_free  = (cnt_reg == 2'd0) || (take && last_slot);

    always_comb
    begin
        case (pos_reg)
            2'd1:    cur = slots_reg[1];
            2'd2:    cur = slots_reg[2];
            default: cur = slots_reg[0];
        endcase
    end

    assign kind      = cur.kind;
    assign data_byte = cur.data_byte;
    assign arg_index = cur.arg_index;
    assign last      = last_slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            pos_reg <= 2'd0;
        end
        else if (grp.load)
        begin
            cnt_reg <= grp.count;
            pos_reg <= 2'd0;
        end
        else if (take)
        begin
            if (last_slot)
            begin
                cnt_reg <= 2'd0;
                pos_reg <= 2'd0;
            end
            else
            begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp.load)
        begin
            slots_reg <= grp.res;
        end
    end

    a_pos_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd0 |-> pos_reg < cnt_reg)
        else $error("result position beyond group");

endmodule

FILE: rtl/command_line_tokenizer.sv
// top level of the command-line tokenizer
// depends on clt_pkg, clt_cfg, clt_scan, clt_emit

// Splits a command line, fed one byte per item with byte 0 ending the line, into
// argument bytes, end-of-argument marks and a final end-of-line count. Quoting with
// single or double quotes and backslash escapes of quotes and backslash are honored;
// arguments at or beyond arg_limit (register 0, byte address 0; zero means 255) are
// dropped. An input byte enters an input register and is decoded from there into a
// group of zero to three results held in a result buffer, which drains one result
// per cycle while out_ready is high; the first result of an item shows once the item
// has passed the input register and the result buffer. The block takes one byte per
// cycle while each byte yields at most one result and out_ready is high; a byte that
// yields more (three at most) holds the input while the buffer drains, which sets the rate.

module command_line_tokenizer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [clt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [clt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [clt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       in_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       kind,
    output logic [7:0]                       data_byte,
    output logic [7:0]                       arg_index,
    output logic                             last
);
    import clt_pkg::*;

    logic [7:0] arg_limit;
    logic       grp_free;
    group_t     grp;

    clt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .arg_limit (arg_limit)
    );

    clt_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .arg_limit (arg_limit),
        .grp_free  (grp_free),
        .grp       (grp)
    );

    clt_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp       (grp),
        .grp_free  (grp_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .data_byte (data_byte),
        .arg_index (arg_index),
        .last      (last)
    );

endmodule
